// File: rtl/polu_pkg.sv
package polu_pkg;

  localparam int unsigned OpW         = 3;
  localparam int unsigned PosW        = 5;
  localparam int unsigned ValW        = 8;
  localparam int unsigned StW         = 3;
  localparam int unsigned CntW        = 5;
  localparam int unsigned DefCapacity = 16;
  // cells the scanner inspects per cycle
  localparam int unsigned ScanGroup   = 8;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_DELETE = 3'd2,
    OP_WRITE  = 3'd3,
    OP_FIND   = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } st_e;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [PosW-1:0] position;
    logic [ValW-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [ValW-1:0] read_value;
    logic [PosW-1:0] found_position;
    logic [CntW-1:0] element_count;
  } res_t;

  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } cell_ctl_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [PosW-1:0] pos;
  } scan_res_t;

endpackage

// File: rtl/polu_cell.sv
module polu_cell (
  input  logic                      clk_i,
  input  polu_pkg::cell_ctl_t       ctl_i,
  input  logic [polu_pkg::ValW-1:0] din_i,
  input  logic [polu_pkg::ValW-1:0] left_i,
  input  logic [polu_pkg::ValW-1:0] right_i,
  input  logic [polu_pkg::ValW-1:0] key_i,
  output logic [polu_pkg::ValW-1:0] val_o,
  output logic                      match_o
);

  logic [polu_pkg::ValW-1:0] val_q, val_d;

  always_comb begin
    if (ctl_i.load) begin
      val_d = din_i;
    end else if (ctl_i.from_left) begin
      val_d = left_i;
    end else if (ctl_i.from_right) begin
      val_d = right_i;
    end else begin
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign match_o = (val_q == key_i);

endmodule

// File: rtl/polu_scan.sv
module polu_scan #(
  parameter int unsigned Capacity = polu_pkg::DefCapacity
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [Capacity-1:0]     match_i,
  output logic                    idle_o,
  output polu_pkg::scan_res_t     scan_o
);

  localparam int unsigned Grp = polu_pkg::ScanGroup;
  localparam int unsigned NG  = (Capacity + Grp - 1) / Grp;
  localparam int unsigned SW  = NG * Grp;
  localparam int unsigned GW  = $clog2(NG + 1);
  localparam int unsigned PW  = GW + $clog2(Grp);

  typedef enum logic [1:0] {
    SC_IDLE = 2'b01,
    SC_SCAN = 2'b10
  } scan_state_e;

  scan_state_e          state_q, state_d;
  logic [GW-1:0]        grp_q, grp_d;
  logic [SW-1:0]        sh_q, sh_d;
  logic [Grp-1:0]       low;
  logic [$clog2(Grp)-1:0] pri;
  logic                 hit, last;
  logic [PW-1:0]        pos_w;

  assign low  = sh_q[Grp-1:0];
  assign hit  = |low;
  assign last = (grp_q == GW'(NG - 1));

  always_comb begin
    pri = '0;
    for (int k = Grp - 1; k >= 0; k--) begin
      if (low[k]) pri = ($clog2(Grp))'(k);
    end
  end

  assign pos_w        = PW'({grp_q, pri}) + PW'(1);
  assign scan_o.done  = (state_q == SC_SCAN) && (hit || last);
  assign scan_o.found = hit;
  assign scan_o.pos   = polu_pkg::PosW'(pos_w);
  assign idle_o       = (state_q == SC_IDLE);

  always_comb begin
    state_d = state_q;
    grp_d   = grp_q;
    sh_d    = sh_q;
    unique case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_SCAN;
          grp_d   = '0;
          sh_d    = SW'(match_i);
        end
      end
      SC_SCAN: begin
        if (scan_o.done) begin
          state_d = SC_IDLE;
        end else begin
          // advance to the next group of cells
          grp_d = grp_q + GW'(1);
          sh_d  = sh_q >> Grp;
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      grp_q   <= '0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

endmodule

// File: rtl/polu_obuf.sv
module polu_obuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_valid_i,
  input  polu_pkg::res_t  res_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output polu_pkg::res_t  out_data_o
);

  polu_pkg::res_t out_q, out_d, pend_q, pend_d;
  logic           out_vld_q, out_vld_d, pend_vld_q, pend_vld_d;
  logic           out_free;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    if (pend_vld_q) begin
      if (out_free) begin
        out_d      = pend_q;
        out_vld_d  = 1'b1;
        pend_vld_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (out_free) begin
        out_d     = res_i;
        out_vld_d = 1'b1;
      end else begin
        // hold in the skid slot until the output register frees
        pend_d     = res_i;
        pend_vld_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign ready_o     = !pend_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/positional_ordered_list_unit.sv
// Ordered byte list held in a shifting row of cells.
// Results are registered in the output buffer, or held in its skid slot while the output stalls;
// find starts a scan of the match vector, the scanner checking 8 cells per cycle.
// Throughput: one request per cycle except find, which holds the input until the scan ends;
// the input also holds while a result waits in the skid slot behind a stalled output.
// Reset clears the element count, scanner state and output valid; cell contents are not reset.
module positional_ordered_list_unit #(
  parameter int unsigned CAPACITY = polu_pkg::DefCapacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  polu_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output polu_pkg::res_t  out_data_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CW > polu_pkg::PosW) ? CW : polu_pkg::PosW) + 1;

  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CmpW-1:0]           cnt_ext, pos_ext, slot;
  logic                      acc, pos_zero, ins_bad, rng_bad, empty, full;
  logic                      do_ins, do_app, do_del, do_wr, scan_start, res_vld;
  logic                      scan_idle, buf_ready;
  logic [polu_pkg::ValW-1:0] rd_val;
  polu_pkg::res_t            res;
  polu_pkg::scan_res_t       scan;
  polu_pkg::cell_ctl_t       ctl      [CAPACITY];
  logic [polu_pkg::ValW-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]       cell_match, match_vec;

  assign in_ready_o = scan_idle && buf_ready;
  assign acc        = in_valid_i && in_ready_o;

  assign cnt_ext  = CmpW'(cnt_q);
  assign pos_ext  = CmpW'(in_data_i.position);
  assign slot     = pos_ext - CmpW'(1);
  assign pos_zero = (in_data_i.position == '0);
  assign ins_bad  = pos_zero || (pos_ext > cnt_ext + CmpW'(1));
  assign rng_bad  = pos_zero || (pos_ext > cnt_ext);
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_ext >= CmpW'(CAPACITY));

  always_comb begin
    rd_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (CmpW'(k) == slot) rd_val = cell_val[k];
    end
  end

  always_comb begin
    res        = '0;
    res_vld    = 1'b0;
    scan_start = 1'b0;
    do_ins     = 1'b0;
    do_app     = 1'b0;
    do_del     = 1'b0;
    do_wr      = 1'b0;
    cnt_d      = cnt_q;
    res.status = polu_pkg::ST_OK;
    if (acc) begin
      res_vld = 1'b1;
      unique case (in_data_i.operation) inside
        polu_pkg::OP_INSERT: begin
          if (ins_bad) begin
            res.status = polu_pkg::ST_BAD_POS;
          end else if (full) begin
            res.status = polu_pkg::ST_FULL;
          end else begin
            do_ins = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
        end
        polu_pkg::OP_APPEND: begin
          if (full) begin
            res.status = polu_pkg::ST_FULL;
          end else begin
            do_app = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
        end
        polu_pkg::OP_DELETE, polu_pkg::OP_WRITE, polu_pkg::OP_READ: begin
          if (empty) begin
            res.status = polu_pkg::ST_EMPTY;
          end else if (rng_bad) begin
            res.status = polu_pkg::ST_BAD_POS;
          end else if (in_data_i.operation == polu_pkg::OP_DELETE) begin
            do_del = 1'b1;
            cnt_d  = cnt_q - CW'(1);
          end else if (in_data_i.operation == polu_pkg::OP_WRITE) begin
            do_wr = 1'b1;
          end else begin
            res.read_value = rd_val;
          end
        end
        polu_pkg::OP_FIND: begin
          if (empty) begin
            res.status = polu_pkg::ST_EMPTY;
          end else begin
            scan_start = 1'b1;
            res_vld    = 1'b0;
          end
        end
        default: ;
      endcase
      res.element_count = polu_pkg::CntW'(cnt_d);
    end else if (scan.done) begin
      res_vld              = 1'b1;
      res.status           = scan.found ? polu_pkg::ST_OK : polu_pkg::ST_NOT_FOUND;
      res.found_position   = scan.found ? scan.pos : '0;
      res.element_count    = polu_pkg::CntW'(cnt_q);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [polu_pkg::ValW-1:0] left, right;

    assign ctl[i].load       = ((do_ins || do_wr) && (CmpW'(i) == slot))
                             || (do_app && (CmpW'(i) == cnt_ext));
    assign ctl[i].from_left  = do_ins && (CmpW'(i) > slot);
    assign ctl[i].from_right = do_del && (CmpW'(i) >= slot);

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_val[i+1];
    end

    polu_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[i]),
      .din_i   (in_data_i.item_value),
      .left_i  (left),
      .right_i (right),
      .key_i   (in_data_i.item_value),
      .val_o   (cell_val[i]),
      .match_o (cell_match[i])
    );

    // drop matches from cells past the end of the list
    assign match_vec[i] = cell_match[i] && (CmpW'(i) < cnt_ext);
  end

  polu_scan #(
    .Capacity (CAPACITY)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .match_i (match_vec),
    .idle_o  (scan_idle),
    .scan_o  (scan)
  );

  polu_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_vld),
    .res_i       (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_scan_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_idle |-> !in_ready_o)
    else $error("input ready during a find scan");

  a_append_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.operation == polu_pkg::OP_APPEND && !full)
      |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("append did not grow the list");

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = polu_pkg::DefCapacity;
  localparam int NUM_RANDOM = 1350;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_AT    = 500;
  localparam int HOLD_LEN   = 300;
  localparam int MAX_PRINTS = 40;

  // operation codes the block does not define
  localparam logic [polu_pkg::OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [polu_pkg::OpW-1:0] OP_SPARE7 = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIX    = 2;

  localparam int RX_OPEN     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_SPARSE   = 3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  polu_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  polu_pkg::res_t out_data_o;

  positional_ordered_list_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  polu_pkg::req_t pending_reqs[$];
  polu_pkg::res_t expected_results[$];

  // predicted list contents
  logic [polu_pkg::ValW-1:0] list_cells [CAP];
  int list_len;

  // element count as the request generator sees it
  int gen_len;

  int n_err;
  int n_in;
  int n_out;
  int n_full;
  int n_found;
  int n_bad_pos;
  int idle_cycles;
  logic took_in;

  task automatic report_mismatch(input string msg);
    if (n_err < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    n_err++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d want %0d", n_out, name, got, want));
  endtask

  task automatic predict_result(input polu_pkg::req_t r, output polu_pkg::res_t e);
    int p;
    int i;
    polu_pkg::st_e st;
    logic [polu_pkg::ValW-1:0] rd;
    logic [polu_pkg::PosW-1:0] fp;
    p = int'(r.position);
    st = polu_pkg::ST_OK;
    rd = '0;
    fp = '0;
    case (r.operation)
      polu_pkg::OP_INSERT: begin
        if (p < 1 || p > list_len + 1) st = polu_pkg::ST_BAD_POS;
        else if (list_len >= CAP) st = polu_pkg::ST_FULL;
        else begin
          for (i = list_len; i > p - 1; i--) list_cells[i] = list_cells[i-1];
          list_cells[p-1] = r.item_value;
          list_len++;
        end
      end
      polu_pkg::OP_APPEND: begin
        if (list_len >= CAP) st = polu_pkg::ST_FULL;
        else begin
          list_cells[list_len] = r.item_value;
          list_len++;
        end
      end
      polu_pkg::OP_DELETE: begin
        if (list_len == 0) st = polu_pkg::ST_EMPTY;
        else if (p < 1 || p > list_len) st = polu_pkg::ST_BAD_POS;
        else begin
          for (i = p - 1; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      polu_pkg::OP_WRITE: begin
        if (list_len == 0) st = polu_pkg::ST_EMPTY;
        else if (p < 1 || p > list_len) st = polu_pkg::ST_BAD_POS;
        else list_cells[p-1] = r.item_value;
      end
      polu_pkg::OP_FIND: begin
        if (list_len == 0) st = polu_pkg::ST_EMPTY;
        else begin
          st = polu_pkg::ST_NOT_FOUND;
          for (i = 0; i < list_len; i++) begin
            if (st == polu_pkg::ST_NOT_FOUND && list_cells[i] == r.item_value) begin
              st = polu_pkg::ST_OK;
              fp = polu_pkg::PosW'(i + 1);
            end
          end
        end
      end
      polu_pkg::OP_READ: begin
        if (list_len == 0) st = polu_pkg::ST_EMPTY;
        else if (p < 1 || p > list_len) st = polu_pkg::ST_BAD_POS;
        else rd = list_cells[p-1];
      end
      default: ;
    endcase
    e.status = st;
    e.read_value = rd;
    e.found_position = fp;
    e.element_count = polu_pkg::CntW'(list_len);
  endtask

  // queue a request and track the count the list will have after it
  task automatic queue_req(input logic [polu_pkg::OpW-1:0] op, input int p, input int v);
    polu_pkg::req_t r;
    r.operation = op;
    r.position = polu_pkg::PosW'(p);
    r.item_value = polu_pkg::ValW'(v);
    pending_reqs.push_back(r);
    case (op)
      polu_pkg::OP_INSERT: if (p >= 1 && p <= gen_len + 1 && gen_len < CAP) gen_len++;
      polu_pkg::OP_APPEND: if (gen_len < CAP) gen_len++;
      polu_pkg::OP_DELETE: if (gen_len > 0 && p >= 1 && p <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic int pick_pos(input logic [polu_pkg::OpW-1:0] op);
    int top;
    top = (op == polu_pkg::OP_INSERT) ? gen_len + 1 : gen_len;
    if (top < 1 || $urandom_range(0, 99) < 20) return $urandom_range(0, 31);
    return $urandom_range(1, top);
  endfunction

  task automatic queue_random(input int mode);
    int r;
    logic [polu_pkg::OpW-1:0] op;
    int v;
    r = $urandom_range(0, 99);
    if (r < 3) op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    else if (mode == MODE_GROW) begin
      if (r < 45) op = polu_pkg::OP_INSERT;
      else if (r < 72) op = polu_pkg::OP_APPEND;
      else if (r < 84) op = polu_pkg::OP_FIND;
      else if (r < 92) op = polu_pkg::OP_READ;
      else if (r < 97) op = polu_pkg::OP_WRITE;
      else op = polu_pkg::OP_DELETE;
    end else if (mode == MODE_SHRINK) begin
      if (r < 50) op = polu_pkg::OP_DELETE;
      else if (r < 60) op = polu_pkg::OP_INSERT;
      else if (r < 75) op = polu_pkg::OP_FIND;
      else if (r < 88) op = polu_pkg::OP_READ;
      else if (r < 96) op = polu_pkg::OP_WRITE;
      else op = polu_pkg::OP_APPEND;
    end else begin
      op = polu_pkg::OpW'($urandom_range(0, 5));
    end
    // a small pool of values makes find hits common
    v = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
    queue_req(op, pick_pos(op), v);
  endtask

  // sender: bursts of transfers separated by random gaps
  int burst_left;
  int gap_left;

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      burst_left <= $urandom_range(1, 40);
      gap_left <= 0;
    end else if (!in_valid_i || took_in) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_reqs.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall patterns plus one long hold-off
  int rx_kind;
  int rx_left;
  int rx_phase;
  int rx_period;
  int hold_left;
  bit hold_done;

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_kind <= RX_OPEN;
      rx_left <= 0;
      rx_phase <= 0;
      rx_period <= 4;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_in >= HOLD_AT) begin
      out_ready_i <= 1'b0;
      hold_left <= HOLD_LEN - 1;
      hold_done <= 1'b1;
    end else if (rx_left == 0) begin
      rx_kind <= $urandom_range(RX_OPEN, RX_SPARSE);
      rx_left <= $urandom_range(20, 150);
      rx_period <= $urandom_range(2, 8);
      rx_phase <= 0;
      out_ready_i <= 1'b1;
    end else begin
      rx_left <= rx_left - 1;
      rx_phase <= (rx_phase + 1) % rx_period;
      case (rx_kind)
        RX_OPEN: out_ready_i <= 1'b1;
        RX_COIN: out_ready_i <= ($urandom_range(0, 1) == 1);
        RX_PERIODIC: out_ready_i <= (rx_phase != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // transfers on both channels, prediction, checking and the watchdog
  always @(posedge clk_i) begin
    polu_pkg::res_t want;
    polu_pkg::res_t got;
    bit any;
    if (rst_ni) begin
      any = 1'b0;
      took_in <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predict_result(in_data_i, want);
        expected_results.push_back(want);
        n_in++;
        any = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        any = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("status", int'(got.status), int'(want.status));
          check_field("read_value", int'(got.read_value), int'(want.read_value));
          check_field("found_position", int'(got.found_position),
                      int'(want.found_position));
          check_field("element_count", int'(got.element_count),
                      int'(want.element_count));
          if (want.status == polu_pkg::ST_FULL) n_full++;
          if (want.status == polu_pkg::ST_BAD_POS) n_bad_pos++;
          if (want.status == polu_pkg::ST_OK && want.found_position != '0) n_found++;
        end
        n_out++;
      end
      idle_cycles <= any ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end else begin
      took_in <= 1'b0;
      idle_cycles <= 0;
    end
  end

  initial begin
    int mode;
    int chunk;
    int i;
    n_err = 0;
    n_in = 0;
    n_out = 0;
    n_full = 0;
    n_found = 0;
    n_bad_pos = 0;
    list_len = 0;
    gen_len = 0;
    for (i = 0; i < CAP; i++) list_cells[i] = '0;

    // empty list
    queue_req(polu_pkg::OP_READ, 1, 0);
    queue_req(polu_pkg::OP_DELETE, 1, 0);
    queue_req(polu_pkg::OP_FIND, 0, 0);
    queue_req(polu_pkg::OP_WRITE, 1, 'hAA);
    queue_req(OP_SPARE6, 31, 'hFF);
    queue_req(OP_SPARE7, 0, 'h55);
    queue_req(polu_pkg::OP_INSERT, 0, 'h11);
    queue_req(polu_pkg::OP_INSERT, 2, 'h11);
    // small list
    queue_req(polu_pkg::OP_INSERT, 1, 'h00);
    queue_req(polu_pkg::OP_APPEND, 31, 'hFF);
    queue_req(polu_pkg::OP_INSERT, 2, 'h80);
    queue_req(polu_pkg::OP_FIND, 7, 'h80);
    queue_req(polu_pkg::OP_FIND, 0, 'h11);
    queue_req(polu_pkg::OP_READ, 0, 0);
    queue_req(polu_pkg::OP_READ, 3, 0);
    queue_req(polu_pkg::OP_READ, 4, 0);
    queue_req(polu_pkg::OP_WRITE, 3, 'h7F);
    queue_req(polu_pkg::OP_DELETE, 0, 0);
    queue_req(polu_pkg::OP_DELETE, 2, 0);
    // fill up, then probe the full list
    while (gen_len < CAP) queue_req(polu_pkg::OP_APPEND, 0, 'hF0 + gen_len);
    queue_req(polu_pkg::OP_INSERT, 0, 'h01);
    queue_req(polu_pkg::OP_INSERT, CAP + 1, 'h02);
    queue_req(polu_pkg::OP_APPEND, 0, 'h03);
    queue_req(polu_pkg::OP_FIND, 0, 'hFF);
    queue_req(polu_pkg::OP_READ, CAP, 0);
    queue_req(polu_pkg::OP_DELETE, CAP, 0);
    queue_req(polu_pkg::OP_DELETE, 1, 0);

    i = 0;
    while (i < NUM_RANDOM) begin
      mode = $urandom_range(MODE_GROW, MODE_MIX);
      chunk = $urandom_range(20, 80);
      repeat (chunk) begin
        if (i < NUM_RANDOM) begin
          queue_random(mode);
          i++;
        end
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run covered %0d requests and %0d checked results, %0d on a full list,",
             n_in, n_out, n_full);
    $display("%0d with a bad position, %0d find hits, and one output hold-off of %0d cycles",
             n_bad_pos, n_found, HOLD_LEN);
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", n_err);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
